FILE: hw/rtl/trt_pkg.sv
// Package for the turn restriction table: commands, status codes, request and result payloads.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package trt_pkg;
  localparam int unsigned NODE_W = 32;
  localparam int unsigned CNT_W  = 12;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REKEY  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_IGNORED     = 3'd1,
    ST_FULL        = 3'd2,
    ST_BUCKET_FULL = 3'd3,
    ST_ABSENT      = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_c;
    logic              only_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              restricted;
    logic              has_only;
    logic [NODE_W-1:0] only_target;
    logic              is_via;
    logic [CNT_W-1:0]  total_count;
  } rsp_t;
endpackage
`default_nettype wire

FILE: hw/rtl/trt_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on trt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface trt_req_if import trt_pkg::*; (input wire logic clk);
  logic valid;
  logic ready;
  logic [1:0]        cmd;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [NODE_W-1:0] node_c;
  logic              only_flag;
  modport source (output valid, cmd, node_a, node_b, node_c, only_flag, input ready);
  modport sink   (input valid, cmd, node_a, node_b, node_c, only_flag, output ready);
endinterface

interface trt_rsp_if import trt_pkg::*; (input wire logic clk);
  logic valid;
  logic ready;
  logic [2:0]        status;
  logic              restricted;
  logic              has_only;
  logic [NODE_W-1:0] only_target;
  logic              is_via;
  logic [CNT_W-1:0]  total_count;
  modport source (output valid, status, restricted, has_only, only_target, is_via,
                  total_count, input ready);
  modport sink   (input valid, status, restricted, has_only, only_target, is_via,
                  total_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/trt_seq.sv
// Sequencer and shared compare unit: walks key, via and bucket memories one
// address per cycle. Depends on trt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trt_seq import trt_pkg::*; #(
  parameter int unsigned KEY_SLOTS    = 256,
  parameter int unsigned BUCKET_DEPTH = 8,
  parameter int unsigned VIA_SLOTS    = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);
  localparam int unsigned KW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned VW = (VIA_SLOTS > 1) ? $clog2(VIA_SLOTS) : 1;
  localparam int unsigned BW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned EW = KW + BW;
  localparam int unsigned FW = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned IW = ((KW > VW) ? KW : VW) + 1;
  localparam int unsigned ESIZE = KEY_SLOTS * (2 ** BW);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_VIA    = 11'b00000000010,
    S_KEY    = 11'b00000000100,
    S_KEY2   = 11'b00000001000,
    S_DEC    = 11'b00000010000,
    S_HEAD   = 11'b00000100000,
    S_INS    = 11'b00001000000,
    S_WALK   = 11'b00010000000,
    S_REKEY  = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_BK     = 11'b10000000000
  } state_t;

  logic [NODE_W-1:0] key_from [KEY_SLOTS];
  logic [NODE_W-1:0] key_via  [KEY_SLOTS];
  logic [KW-1:0]     key_bucket [KEY_SLOTS];
  logic [NODE_W-1:0] entry_target [ESIZE];
  logic              entry_only   [ESIZE];
  logic [FW-1:0]     bucket_fill  [KEY_SLOTS];
  logic [NODE_W-1:0] via_mem [VIA_SLOTS];
  logic [KEY_SLOTS-1:0] key_valid_r;

  state_t state_r;
  req_t   req_r;
  rsp_t   rsp_r;
  logic [KW:0] buckets_used_r;
  logic [VW:0] via_used_r;
  logic [CNT_W-1:0] total_r;
  logic [IW-1:0] idx_r;
  logic [BW:0] eidx_r;
  logic found_r, found2_r, via_hit_r, free_ok_r, walk_only_r;
  logic [KW-1:0] kslot_r, free_r, bk_r;
  logic [NODE_W-1:0] rd_from_r, rd_via_r, rd_via_node_r, rd_tgt_r;
  logic [KW-1:0] rd_bk_r;
  logic [FW-1:0] rd_fill_r;
  logic rd_only_r, rd_ok_r;

  logic [NODE_W-1:0] cmp_a, cmp_b;
  logic [NODE_W-1:0] cmp_c, cmp_d;
  logic cmp_eq;
  assign cmp_eq = (cmp_a == cmp_b) && (cmp_c == cmp_d);

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_OUT);
  assign rsp = rsp_r;

  logic [KW-1:0] ridx;
  logic [EW-1:0] eaddr;
  assign ridx  = idx_r[KW-1:0];
  assign eaddr = {bk_r, eidx_r[BW-1:0]};

  always_ff @(posedge clk) begin
    rd_from_r     <= key_from[ridx];
    rd_via_r      <= key_via[ridx];
    rd_via_node_r <= via_mem[idx_r[VW-1:0]];
    rd_bk_r       <= key_bucket[kslot_r];
    rd_fill_r     <= bucket_fill[bk_r];
    rd_tgt_r      <= entry_target[eaddr];
    rd_only_r     <= entry_only[eaddr];
  end

  rsp_t rsp_clr;
  always_comb begin
    rsp_clr = '0;
    rsp_clr.total_count = total_r;
  end

  always_comb begin
    cmp_a = rd_from_r;
    cmp_b = req_r.node_a;
    cmp_c = rd_via_r;
    cmp_d = req_r.node_b;
    case (state_r)
      S_VIA: begin
        cmp_a = rd_via_node_r; cmp_b = req_r.node_b; cmp_c = '0; cmp_d = '0;
      end
      S_KEY: begin
        if (req_r.cmd == CMD_REKEY) begin
          cmp_b = req_r.node_b; cmp_d = req_r.node_c;
        end
      end
      S_KEY2: begin
        cmp_b = req_r.node_a; cmp_d = req_r.node_c;
      end
      S_WALK: begin
        cmp_a = rd_tgt_r; cmp_b = req_r.node_c; cmp_c = '0; cmp_d = '0;
      end
      default: ;
    endcase
  end

  logic [FW-1:0] new_fill;
  assign new_fill = req_r.only_flag ? '0 : rd_fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_valid_r <= '0;
      buckets_used_r <= '0;
      via_used_r <= '0;
      total_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req;
            idx_r <= '0;
            rd_ok_r <= 1'b0;
            via_hit_r <= 1'b0;
            found_r <= 1'b0;
            found2_r <= 1'b0;
            free_ok_r <= 1'b0;
            rsp_r <= rsp_clr;
            if (req.cmd == CMD_REKEY) state_r <= S_KEY;
            else if (req.cmd == CMD_NONE) state_r <= S_OUT;
            else state_r <= S_VIA;
          end
        end
        S_VIA: begin
          // registered read: rd_ok_r marks data of idx_r-1 valid
          if (rd_ok_r && ((VW+1)'(idx_r) <= via_used_r) && cmp_eq)
            via_hit_r <= 1'b1;
          if (idx_r == IW'(VIA_SLOTS)) begin
            idx_r <= '0; rd_ok_r <= 1'b0; state_r <= S_KEY;
          end else begin
            idx_r <= idx_r + 1'b1; rd_ok_r <= 1'b1;
          end
        end
        S_KEY, S_KEY2: begin
          if (rd_ok_r) begin
            if (key_valid_r[KW'(idx_r - 1'b1)] && cmp_eq) begin
              if (state_r == S_KEY && !found_r) begin
                found_r <= 1'b1; kslot_r <= KW'(idx_r - 1'b1);
              end
              if (state_r == S_KEY2) found2_r <= 1'b1;
            end
            if (state_r == S_KEY && !key_valid_r[KW'(idx_r - 1'b1)] && !free_ok_r) begin
              free_ok_r <= 1'b1; free_r <= KW'(idx_r - 1'b1);
            end
          end
          if (idx_r == IW'(KEY_SLOTS)) begin
            idx_r <= '0; rd_ok_r <= 1'b0;
            if (state_r == S_KEY && req_r.cmd == CMD_REKEY) state_r <= S_KEY2;
            else if (state_r == S_KEY2) state_r <= S_REKEY;
            else state_r <= S_BK;
          end else begin
            idx_r <= idx_r + 1'b1; rd_ok_r <= 1'b1;
          end
        end
        S_BK: state_r <= S_DEC;
        S_REKEY: begin
          rsp_r.total_count <= total_r;
          if (!found_r) rsp_r.status <= ST_ABSENT;
          else if (req_r.node_a != req_r.node_b) begin
            if (found2_r) key_valid_r[kslot_r] <= 1'b0;
            else key_from[kslot_r] <= req_r.node_a;
          end
          state_r <= S_OUT;
        end
        S_DEC: begin
          // rd_bk_r valid now for kslot_r
          rsp_r.total_count <= total_r;
          if (req_r.cmd == CMD_QUERY) begin
            rsp_r.is_via <= via_hit_r;
            if (!found_r) begin
              rsp_r.status <= ST_ABSENT; state_r <= S_OUT;
            end else begin
              bk_r <= rd_bk_r; eidx_r <= '0;
              rd_ok_r <= 1'b0; walk_only_r <= 1'b0; state_r <= S_WALK;
            end
          end else begin
            if (!via_hit_r && via_used_r >= (VW+1)'(VIA_SLOTS)) begin
              rsp_r.status <= ST_FULL; state_r <= S_OUT;
            end else if (!found_r && (!free_ok_r ||
                         buckets_used_r >= (KW+1)'(KEY_SLOTS))) begin
              rsp_r.status <= ST_FULL; state_r <= S_OUT;
            end else begin
              if (!via_hit_r) begin
                via_mem[via_used_r[VW-1:0]] <= req_r.node_b;
                via_used_r <= via_used_r + 1'b1;
              end
              if (!found_r) begin
                key_valid_r[free_r] <= 1'b1;
                key_from[free_r] <= req_r.node_a;
                key_via[free_r] <= req_r.node_b;
                key_bucket[free_r] <= buckets_used_r[KW-1:0];
                bucket_fill[buckets_used_r[KW-1:0]] <= '0;
                buckets_used_r <= buckets_used_r + 1'b1;
                bk_r <= buckets_used_r[KW-1:0];
              end else begin
                bk_r <= rd_bk_r;
              end
              eidx_r <= '0;
              state_r <= S_HEAD;
            end
          end
        end
        S_HEAD: state_r <= S_INS;
        S_INS: begin
          // rd_only_r and rd_fill_r hold the bucket head and fill
          if (rd_fill_r != '0 && rd_only_r) begin
            rsp_r.status <= ST_IGNORED; state_r <= S_OUT;
          end else begin
            if (new_fill >= FW'(BUCKET_DEPTH)) begin
              rsp_r.status <= ST_BUCKET_FULL;
              rsp_r.total_count <= total_r;
            end else begin
              entry_target[{bk_r, new_fill[BW-1:0]}] <= req_r.node_c;
              entry_only[{bk_r, new_fill[BW-1:0]}] <= req_r.only_flag;
              bucket_fill[bk_r] <= new_fill + 1'b1;
              total_r <= total_r - CNT_W'(req_r.only_flag ? rd_fill_r : '0) + 1'b1;
              rsp_r.total_count <= total_r - CNT_W'(req_r.only_flag ? rd_fill_r : '0)
                                   + 1'b1;
            end
            state_r <= S_OUT;
          end
        end
        S_WALK: begin
          if (rd_ok_r && (eidx_r - 1'b1) < (BW+1)'(rd_fill_r)) begin
            if (cmp_eq != rd_only_r) rsp_r.restricted <= 1'b1;
            if (rd_only_r && !walk_only_r) begin
              walk_only_r <= 1'b1;
              rsp_r.has_only <= 1'b1;
              rsp_r.only_target <= rd_tgt_r;
            end
          end
          if (eidx_r == (BW+1)'(BUCKET_DEPTH)) state_r <= S_OUT;
          else begin
            eidx_r <= eidx_r + 1'b1; rd_ok_r <= 1'b1;
          end
        end
        S_OUT: if (rsp_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/turn_restriction_table_unit.sv
// Top level of the turn restriction table: channel ports and sequencer.
// Depends on trt_pkg, trt_if and trt_seq.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time; the request channel is not ready until the result beat
// is taken. After the accept cycle, insert and query scan the via list and
// the key table, then fetch the bucket index and decide. An insert with room
// then reads the bucket head and fill and decides whether to write the entry;
// a query of a present key walks the bucket. A rekey scans the key table
// twice and then updates. The result shows from the next cycle until taken.
// Each scan reads one memory entry per cycle through a single comparator.
// No clearing pass.
module turn_restriction_table_unit import trt_pkg::*; #(
  parameter int unsigned KEY_SLOTS    = 256,
  parameter int unsigned BUCKET_DEPTH = 8,
  parameter int unsigned VIA_SLOTS    = 256
) (
  input wire logic  clk,
  input wire logic  rst_n,
  trt_req_if.sink   in_ch,
  trt_rsp_if.source out_ch
);
  req_t req;
  rsp_t rsp;
  assign req.cmd = in_ch.cmd;
  assign req.node_a = in_ch.node_a;
  assign req.node_b = in_ch.node_b;
  assign req.node_c = in_ch.node_c;
  assign req.only_flag = in_ch.only_flag;

  trt_seq #(.KEY_SLOTS(KEY_SLOTS), .BUCKET_DEPTH(BUCKET_DEPTH), .VIA_SLOTS(VIA_SLOTS))
  u_seq (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req(req),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp(rsp)
  );

  assign out_ch.status = rsp.status;
  assign out_ch.restricted = rsp.restricted;
  assign out_ch.has_only = rsp.has_only;
  assign out_ch.only_target = rsp.only_target;
  assign out_ch.is_via = rsp.is_via;
  assign out_ch.total_count = rsp.total_count;
endmodule
`default_nettype wire

FILE: hw/rtl/trt_checker.sv
// Port-level checker for the turn restriction table, bound to the top level.
// Depends on trt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trt_checker import trt_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] out_status,
  input wire logic out_restricted,
  input wire logic out_has_only
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted twice");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'(ST_ABSENT))
    else $error("bad status");
  a_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'(ST_DONE) |-> !out_restricted && !out_has_only)
    else $error("restricted flags on failed step");
endmodule

bind turn_restriction_table_unit trt_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_restricted(out_ch.restricted), .out_has_only(out_ch.has_only)
);
`default_nettype wire
